[hw/rtl/uecal_pkg.sv]
// Shared types, codes and constant tables of the epoch-to-calendar unit.
// No dependencies; imported by the controller, the datapath, the top level and the checker.
package uecal_pkg;

	localparam int SEC_W = 39;  // magnitude of a non-negative timestamp

	localparam logic [11:0] EPOCH_YEAR = 12'd1970;
	localparam logic [6:0]  EPOCH_Y100 = 7'd70;   // 1970 mod 100
	localparam logic [8:0]  EPOCH_Y400 = 9'd370;  // 1970 mod 400
	localparam logic [2:0]  EPOCH_WDAY = 3'd4;    // 1970-01-01 was a Thursday

	localparam logic [SEC_W-1:0] SECS_DAY       = 39'd86400;
	localparam logic [SEC_W-1:0] SECS_YEAR      = 39'd31536000;
	localparam logic [SEC_W-1:0] SECS_LEAP_YEAR = 39'd31622400;
	localparam logic [16:0]      SECS_HOUR      = 17'd3600;
	localparam logic [11:0]      SECS_MIN       = 12'd60;

	// reciprocals for the time of day: hour = (s * HOUR_RECIP) >> 27, s < 86400;
	// minute = (s * MIN_RECIP) >> 17, s < 3600
	localparam logic [15:0] HOUR_RECIP = 16'd37283;
	localparam logic [11:0] MIN_RECIP  = 12'd2185;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_NEG   = 2'd1;
	localparam logic [1:0] STATUS_RANGE = 2'd2;

	typedef struct packed {
		logic start;
		logic year_step;
		logic month_step;
		logic day_step;
		logic hour_cap;
		logic hour_rem;
		logic min_cap;
		logic min_rem;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic neg;
		logic year_fit;
		logic year_last;
		logic month_fit;
		logic day_fit;
	} dp_sts_t;

	function automatic logic [4:0] month_len(input logic [3:0] m);
		logic [4:0] n;
		case (m)
			4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: n = 5'd31;
			4'd1:                                      n = 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10:                   n = 5'd30;
			default:                                   n = 5'd31;
		endcase
		return n;
	endfunction

	// seconds in a month of the given length
	function automatic logic [SEC_W-1:0] month_secs(input logic [4:0] dim);
		logic [SEC_W-1:0] s;
		case (dim)
			5'd28:   s = 39'd2419200;
			5'd29:   s = 39'd2505600;
			5'd30:   s = 39'd2592000;
			default: s = 39'd2678400;
		endcase
		return s;
	endfunction

endpackage

[hw/rtl/unix_epoch_to_calendar_unit.sv]
// Top level of the epoch-to-calendar unit: joins the sequencer and the datapath.
// Depends on uecal_pkg, uecal_ctrl and uecal_dp.
//
// Converts a signed 40-bit count of seconds since 1970-01-01 00:00:00 UTC into a
// Gregorian UTC date and time: year, month (0 is January), day of month, hour, minute,
// second and weekday (0 is Sunday). A negative count returns status 1 with all other
// fields zero; an instant on or after January 1 of MAX_YEAR + 1 returns status 2 with
// all other fields zero. One item is converted at a time: ts_ready is high only while
// the unit is idle. The result sits in an output register, so the next item is taken
// while an earlier result still waits on cal_ready. After acceptance the unit runs the
// year, month and day loops, which subtract one year, month or day of seconds per cycle,
// then splits the time of day by two reciprocal multiplies in the hour capture, hour
// remainder, minute capture and minute remainder states, and loads the result register
// once it is empty or its result is taken. A negative input goes from the year state
// straight to the result; an out-of-range one leaves the year loop once it passes
// MAX_YEAR. The next item is accepted no earlier than the cycle after the result is
// loaded.
module unix_epoch_to_calendar_unit
	import uecal_pkg::*;
#(
	parameter int MAX_YEAR = 2099
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               ts_valid,
	output logic               ts_ready,
	input  logic signed [39:0] epoch_seconds,
	output logic               cal_valid,
	input  logic               cal_ready,
	output logic [1:0]         status,
	output logic [11:0]        year,
	output logic [3:0]         month,
	output logic [4:0]         day,
	output logic [4:0]         hour,
	output logic [5:0]         minute,
	output logic [5:0]         second,
	output logic [2:0]         weekday
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequence the calendar loops and the time-of-day split
	uecal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.ts_valid  (ts_valid),
		.ts_ready  (ts_ready),
		.cal_valid (cal_valid),
		.cal_ready (cal_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// hold the working values and the result register
	uecal_dp #(
		.MAX_YEAR (MAX_YEAR)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.epoch_seconds (epoch_seconds),
		.status        (status),
		.year          (year),
		.month         (month),
		.day           (day),
		.hour          (hour),
		.minute        (minute),
		.second        (second),
		.weekday       (weekday)
	);

endmodule

[hw/rtl/uecal_ctrl.sv]
// Sequencer of the epoch-to-calendar unit: year, month and day loops, time-of-day split,
// output handoff. Depends on uecal_pkg; drives uecal_dp through dp_cmd_t and reads dp_sts_t.
module uecal_ctrl
	import uecal_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    ts_valid,
	output logic    ts_ready,
	output logic    cal_valid,
	input  logic    cal_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_YEAR  = 9'b000000010,
		S_MONTH = 9'b000000100,
		S_DAY   = 9'b000001000,
		S_HOUR  = 9'b000010000,
		S_HREM  = 9'b000100000,
		S_MIN   = 9'b001000000,
		S_MREM  = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign ts_ready  = (state_q == S_IDLE);
	assign cal_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (ts_valid) begin
					cmd.start = 1'b1;
					state_d   = S_YEAR;
				end
			end
			S_YEAR: begin
				if (sts.neg) begin
					state_d = S_DONE;
				end else begin
					cmd.year_step = 1'b1;
					if (sts.year_fit) begin
						state_d = S_MONTH;
					end else if (sts.year_last) begin
						state_d = S_DONE;
					end
				end
			end
			S_MONTH: begin
				cmd.month_step = 1'b1;
				if (sts.month_fit) begin
					state_d = S_DAY;
				end
			end
			S_DAY: begin
				cmd.day_step = 1'b1;
				if (sts.day_fit) begin
					state_d = S_HOUR;
				end
			end
			S_HOUR: begin
				cmd.hour_cap = 1'b1;
				state_d      = S_HREM;
			end
			S_HREM: begin
				cmd.hour_rem = 1'b1;
				state_d      = S_MIN;
			end
			S_MIN: begin
				cmd.min_cap = 1'b1;
				state_d     = S_MREM;
			end
			S_MREM: begin
				cmd.min_rem = 1'b1;
				state_d     = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || cal_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (cal_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[hw/rtl/uecal_dp.sv]
// Datapath of the epoch-to-calendar unit: year, month and day subtraction on the seconds
// count with leap-year and weekday tracking, time-of-day split and the result register.
// Depends on uecal_pkg.
module uecal_dp
	import uecal_pkg::*;
#(
	parameter int MAX_YEAR = 2099
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_sts_t            sts,
	input  logic signed [39:0] epoch_seconds,
	output logic [1:0]         status,
	output logic [11:0]        year,
	output logic [3:0]         month,
	output logic [4:0]         day,
	output logic [4:0]         hour,
	output logic [5:0]         minute,
	output logic [5:0]         second,
	output logic [2:0]         weekday
);

	// calendar working state
	logic              neg_q, ovf_q;
	logic [SEC_W-1:0]  sec_q;
	logic [11:0]       year_q;
	logic [6:0]        y100_q;
	logic [8:0]        y400_q;
	logic [3:0]        month_q;
	logic [4:0]        day_q;
	logic [4:0]        hour_q;
	logic [5:0]        minute_q;
	logic [2:0]        wday_q;

	logic              leap;
	logic [4:0]        dim;
	logic [SEC_W-1:0]  ysecs;
	logic [SEC_W-1:0]  msecs;
	logic              at_max;
	logic [2:0]        wday_add;
	logic [3:0]        wday_sum;
	logic [3:0]        wday_wrap;
	logic [2:0]        wday_next;
	logic [31:0]       hour_prod;
	logic [22:0]       min_prod;
	logic [16:0]       hour_secs;
	logic [11:0]       min_secs;
	logic              res_ok;

	logic [1:0]  status_q;
	logic [11:0] year_o_q;
	logic [3:0]  month_o_q;
	logic [4:0]  day_o_q, hour_o_q;
	logic [5:0]  minute_o_q, second_o_q;
	logic [2:0]  wday_o_q;

	assign leap   = ((year_q[1:0] == 2'd0) && (y100_q != 7'd0)) || (y400_q == 9'd0);
	assign ysecs  = leap ? SECS_LEAP_YEAR : SECS_YEAR;
	assign dim    = (month_q == 4'd1) ? (5'd28 + {4'd0, leap}) : month_len(month_q);
	assign msecs  = month_secs(dim);
	assign at_max = (year_q == 12'(MAX_YEAR));

	// advance the weekday by the days just stripped, modulo 7
	always_comb begin
		if (cmd.year_step) begin
			wday_add = leap ? 3'd2 : 3'd1;
		end else if (cmd.month_step) begin
			wday_add = {1'b0, dim[1:0]};
		end else begin
			wday_add = 3'd1;
		end
	end

	assign wday_sum  = {1'b0, wday_q} + {1'b0, wday_add};
	assign wday_wrap = wday_sum - 4'd7;
	assign wday_next = (wday_sum >= 4'd7) ? wday_wrap[2:0] : wday_sum[2:0];

	// time of day by reciprocal multiplication, one product per cycle
	assign hour_prod = {15'd0, sec_q[16:0]} * {16'd0, HOUR_RECIP};
	assign min_prod  = {11'd0, sec_q[11:0]} * {11'd0, MIN_RECIP};
	assign hour_secs = {12'd0, hour_q} * SECS_HOUR;
	assign min_secs  = {6'd0, minute_q} * SECS_MIN;

	assign sts.neg       = neg_q;
	assign sts.year_fit  = (sec_q < ysecs);
	assign sts.year_last = !sts.year_fit && at_max;
	assign sts.month_fit = (sec_q < msecs) || (month_q == 4'd12);
	assign sts.day_fit   = (sec_q < SECS_DAY);

	assign res_ok = !neg_q && !ovf_q;

	// control state: flags that steer the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q <= 1'b0;
			ovf_q <= 1'b0;
		end else if (cmd.start) begin
			neg_q <= epoch_seconds[39];
			ovf_q <= 1'b0;
		end else if (cmd.year_step && sts.year_last) begin
			ovf_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sec_q   <= epoch_seconds[38:0];
			year_q  <= EPOCH_YEAR;
			y100_q  <= EPOCH_Y100;
			y400_q  <= EPOCH_Y400;
			month_q <= '0;
			day_q   <= 5'd1;
			wday_q  <= EPOCH_WDAY;
		end else if (cmd.year_step && !sts.year_fit) begin
			sec_q  <= sec_q - ysecs;
			year_q <= year_q + 12'd1;
			y100_q <= (y100_q == 7'd99) ? 7'd0 : y100_q + 7'd1;
			y400_q <= (y400_q == 9'd399) ? 9'd0 : y400_q + 9'd1;
			wday_q <= wday_next;
		end else if (cmd.month_step && !sts.month_fit) begin
			sec_q   <= sec_q - msecs;
			month_q <= month_q + 4'd1;
			wday_q  <= wday_next;
		end else if (cmd.day_step && !sts.day_fit) begin
			sec_q  <= sec_q - SECS_DAY;
			day_q  <= day_q + 5'd1;
			wday_q <= wday_next;
		end else if (cmd.hour_rem) begin
			sec_q <= {22'd0, sec_q[16:0] - hour_secs};
		end else if (cmd.min_rem) begin
			sec_q <= {27'd0, sec_q[11:0] - min_secs};
		end

		if (cmd.hour_cap) begin
			hour_q <= hour_prod[31:27];
		end
		if (cmd.min_cap) begin
			minute_q <= min_prod[22:17];
		end

		if (cmd.out_load) begin
			status_q   <= neg_q ? STATUS_NEG : (ovf_q ? STATUS_RANGE : STATUS_OK);
			year_o_q   <= res_ok ? year_q : '0;
			month_o_q  <= res_ok ? month_q : '0;
			day_o_q    <= res_ok ? day_q : '0;
			hour_o_q   <= res_ok ? hour_q : '0;
			minute_o_q <= res_ok ? minute_q : '0;
			second_o_q <= res_ok ? sec_q[5:0] : '0;
			wday_o_q   <= res_ok ? wday_q : '0;
		end
	end

	assign status  = status_q;
	assign year    = year_o_q;
	assign month   = month_o_q;
	assign day     = day_o_q;
	assign hour    = hour_o_q;
	assign minute  = minute_o_q;
	assign second  = second_o_q;
	assign weekday = wday_o_q;

endmodule

[hw/rtl/uecal_checker.sv]
// Port-level checks of the epoch-to-calendar unit, attached to the top level by bind.
// Depends on uecal_pkg and unix_epoch_to_calendar_unit.
module uecal_checker
	import uecal_pkg::*;
#(
	parameter int MAX_YEAR = 2099
) (
	input logic        clk,
	input logic        arst_n,
	input logic        ts_valid,
	input logic        ts_ready,
	input logic        cal_valid,
	input logic        cal_ready,
	input logic [1:0]  status,
	input logic [11:0] year,
	input logic [3:0]  month,
	input logic [4:0]  day,
	input logic [4:0]  hour,
	input logic [5:0]  minute,
	input logic [5:0]  second,
	input logic [2:0]  weekday
);

	// a stalled result holds: cal_valid stays high and status, year, day and second are stable
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cal_valid && !cal_ready |=> cal_valid && $stable(status) && $stable(year)
			&& $stable(day) && $stable(second))
		else $error("stalled result changed");

	// an accepted item makes the unit busy for the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ts_valid && ts_ready |=> !ts_ready)
		else $error("item accepted while busy");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		cal_valid && status == STATUS_OK |-> year >= 12'd1970 && year <= 12'(MAX_YEAR)
			&& month <= 4'd11 && day >= 5'd1 && hour <= 5'd23 && minute <= 6'd59
			&& second <= 6'd59 && weekday <= 3'd6)
		else $error("calendar field out of range");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cal_valid && status != STATUS_OK |-> (status == STATUS_NEG || status == STATUS_RANGE)
			&& year == 12'd0 && month == 4'd0 && day == 5'd0 && hour == 5'd0
			&& minute == 6'd0 && second == 6'd0 && weekday == 3'd0)
		else $error("error result carries nonzero fields");

endmodule

bind unix_epoch_to_calendar_unit uecal_checker #(
	.MAX_YEAR (MAX_YEAR)
) u_uecal_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.ts_valid  (ts_valid),
	.ts_ready  (ts_ready),
	.cal_valid (cal_valid),
	.cal_ready (cal_ready),
	.status    (status),
	.year      (year),
	.month     (month),
	.day       (day),
	.hour      (hour),
	.minute    (minute),
	.second    (second),
	.weekday   (weekday)
);
